[rtl/pbo_pkg.sv]
// Shared types, constants and helpers for the polyBLEP waveform oscillator.
// No dependencies; imported by pbo_div, pbo_ctrl and the top level.
`timescale 1ns / 1ps

package pbo_pkg;

  // Internal fixed-point format: signed, 28 fraction bits
  localparam int FRAC_BITS = 28;
  localparam int WORK_W    = 36;

  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t ONE_Q = work_t'(1) <<< FRAC_BITS;
  localparam work_t TWO_Q = work_t'(2) <<< FRAC_BITS;

  // Triangle integrator, Q3.28
  localparam int INTEG_W = 32;
  localparam logic signed [INTEG_W-1:0] INTEG_ONE = INTEG_W'(1) <<< FRAC_BITS;

  // Waveform codes
  localparam logic [1:0] WF_SINE     = 2'd0;
  localparam logic [1:0] WF_SAW      = 2'd1;
  localparam logic [1:0] WF_SQUARE   = 2'd2;
  localparam logic [1:0] WF_TRIANGLE = 2'd3;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd1;

  localparam logic [1:0]  WAVEFORM_RST  = WF_SAW;
  localparam logic [31:0] PHASE_INC_RST = 32'd42950;

  typedef struct packed {
    logic [1:0]  waveform;
    logic [31:0] phase_increment;
  } pbo_cfg_t;

  // Saturate to +-2.0
  function automatic work_t clamp2(work_t v);
    work_t r;
    if (v > TWO_Q) begin
      r = TWO_Q;
    end else if (v < -TWO_Q) begin
      r = -TWO_Q;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/pbo_div.sv]
// Restoring fractional divider: num/den in Q0.28, one quotient bit a cycle.
// Depends on pbo_pkg. Requires num < den.
`timescale 1ns / 1ps

module pbo_div #(
  parameter int PHASE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [PHASE_WIDTH-1:0]        num,
  input  logic [PHASE_WIDTH-1:0]        den,
  output logic                          done,
  output logic [pbo_pkg::FRAC_BITS-1:0] quo
);
  import pbo_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PHASE_WIDTH-1:0] rem_r, rem_nxt;
  logic [PHASE_WIDTH-1:0] den_r, den_nxt;
  logic [FRAC_BITS-1:0]   quo_r, quo_nxt;

  logic [PHASE_WIDTH:0]   shifted;
  logic [PHASE_WIDTH:0]   diff;
  logic                   ge;

  // One trial subtraction per cycle
  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    ge       = shifted >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[PHASE_WIDTH-1:0] : shifted[PHASE_WIDTH-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/pbo_ctrl.sv]
// Sample sequencer: phase accumulator, sine table, polyBLEP and triangle datapath
// around one shared multiplier and the iterative divider. Depends on pbo_pkg, pbo_div.
`timescale 1ns / 1ps

module pbo_ctrl #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int PHASE_WIDTH      = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbo_pkg::pbo_cfg_t              cfg,
  input  logic                           start,
  input  logic                           sync,
  output logic                           idle,
  output logic                           res_valid,
  output logic signed [SAMPLE_WIDTH-1:0] res_sample,
  input  logic                           res_take
);
  import pbo_pkg::*;

  localparam int PW      = PHASE_WIDTH;
  localparam int AW      = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_W   = 30;
  localparam int PROD_W  = 63;
  localparam int OUT_SHL = (SAMPLE_WIDTH > 31) ? (SAMPLE_WIDTH - 31) : 0;
  localparam int OUT_SHR = (SAMPLE_WIDTH < 31) ? (31 - SAMPLE_WIDTH) : 0;
  localparam work_t RND  = (work_t'(1) <<< OUT_SHR) >>> 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SINE_IDX = 4'd1;
  localparam logic [3:0] S_SINE_RD  = 4'd2;
  localparam logic [3:0] S_SINE_DAT = 4'd3;
  localparam logic [3:0] S_BLEP_CMP = 4'd4;
  localparam logic [3:0] S_BLEP_SEL = 4'd5;
  localparam logic [3:0] S_BLEP_DIV = 4'd6;
  localparam logic [3:0] S_BLEP_MUL = 4'd7;
  localparam logic [3:0] S_BLEP_ACC = 4'd8;
  localparam logic [3:0] S_TRI_MUL  = 4'd9;
  localparam logic [3:0] S_TRI_ADD  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  typedef logic signed [ROM_W-1:0] rom_word_t;
  typedef rom_word_t rom_tbl_t [SINE_TABLE_DEPTH];

  // sin(2*pi*k/depth) in Q.28, Taylor series on the folded quarter wave
  function automatic rom_word_t sine_entry(int unsigned k);
    logic [63:0]        f;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [1:0]         quad;
    f    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    quad = f[31:30];
    r    = {34'd0, f[29:0]};
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    sum  = $signed(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      unique case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    sum = (sum + 64'sd2) >>> 2;
    return quad[1] ? rom_word_t'(-sum) : rom_word_t'(sum);
  endfunction

  function automatic rom_tbl_t build_table();
    rom_tbl_t t;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_tbl_t SINE_TBL = build_table();

  logic [3:0]                state_r, state_nxt;
  logic [PW-1:0]             phase_r, phase_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic [PW-1:0]             p_r, p_nxt;
  logic [PW-1:0]             inc_r, inc_nxt;
  logic [1:0]                wf_r, wf_nxt;
  logic                      pass_r, pass_nxt;
  logic                      lo_r, lo_nxt;
  logic [PW:0]               num_r, num_nxt;
  work_t                     acc_r, acc_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic                      neg_r, neg_nxt;
  rom_word_t                 rom_q_r;

  logic [PW-1:0]             p_sel;
  logic [PW+31:0]            inc_ext;
  logic [PW-1:0]             inc_cur;
  logic [PW+FRAC_BITS-1:0]   p_frac;
  work_t                     saw_base;
  work_t                     sq_base;
  logic [PW+AW-1:0]          sine_prod;
  logic [PW-1:0]             q_cur;
  logic                      hi;
  logic                      blep_last;
  logic [3:0]                route;
  logic                      div_start;
  logic [PW-1:0]             div_num;
  logic                      div_done;
  logic [FRAC_BITS-1:0]      div_quo;
  logic [29:0]               two_minus_t;
  work_t                     abs_acc;
  logic [30:0]               mag;
  logic [31:0]               mul_a;
  logic [30:0]               mul_b;
  logic [PROD_W-1:0]         mul_p;
  work_t                     poly;
  work_t                     blep;
  work_t                     tri_m;
  work_t                     tri_sum;
  work_t                     tri_cl;
  work_t                     out_cl;
  work_t                     out_scaled;

  pbo_div #(
    .PHASE_WIDTH(PW)
  ) u_pbo_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (inc_r),
    .done (div_done),
    .quo  (div_quo)
  );

  // Operand preparation
  always_comb begin
    p_sel     = sync ? '0 : phase_r;
    inc_ext   = {cfg.phase_increment, {PW{1'b0}}};
    inc_cur   = inc_ext[PW+31:32];
    p_frac    = {p_sel, {FRAC_BITS{1'b0}}};
    saw_base  = work_t'({7'd0, p_frac[PW+FRAC_BITS-1:PW], 1'b0}) - ONE_Q;
    sq_base   = p_sel[PW-1] ? ONE_Q : -ONE_Q;
    sine_prod = {{AW{1'b0}}, p_r} * (PW + AW)'(SINE_TABLE_DEPTH);
    q_cur     = pass_r ? {~p_r[PW-1], p_r[PW-2:0]} : p_r;
    hi        = num_r < {1'b0, inc_r};
    div_num   = lo_r ? q_cur : num_r[PW-1:0];
    blep_last = (wf_r == WF_SAW) || pass_r;
    if (!blep_last) begin
      route = S_BLEP_CMP;
    end else if (wf_r == WF_TRIANGLE) begin
      route = S_TRI_MUL;
    end else begin
      route = S_OUT;
    end
  end

  // Shared multiplier: polyBLEP (2 - t) * t, or triangle slope inc * |square|
  always_comb begin
    two_minus_t = {1'b1, 29'd0} - {2'b00, div_quo};
    abs_acc     = acc_r[WORK_W-1] ? -acc_r : acc_r;
    mag         = abs_acc[30:0];
    if (state_r == S_TRI_MUL) begin
      mul_a = cfg.phase_increment;
      mul_b = mag;
    end else begin
      mul_a = {2'b00, two_minus_t};
      mul_b = {3'b000, div_quo};
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Post-multiply arithmetic
  always_comb begin
    poly    = work_t'({6'd0, prod_r[57:28]});
    blep    = lo_r ? (poly - ONE_Q) : (ONE_Q - poly);
    tri_m   = work_t'({3'd0, prod_r[62:30]});
    tri_sum = work_t'(integ_r) + (neg_r ? -tri_m : tri_m);
    tri_cl  = clamp2(tri_sum);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    integ_nxt = integ_r;
    p_nxt     = p_r;
    inc_nxt   = inc_r;
    wf_nxt    = wf_r;
    pass_nxt  = pass_r;
    lo_nxt    = lo_r;
    num_nxt   = num_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          p_nxt     = p_sel;
          phase_nxt = p_sel + inc_cur;
          inc_nxt   = inc_cur;
          wf_nxt    = cfg.waveform;
          pass_nxt  = 1'b0;
          acc_nxt   = (cfg.waveform == WF_SAW) ? saw_base : sq_base;
          if (sync) begin
            integ_nxt = INTEG_ONE;
          end
          state_nxt = (cfg.waveform == WF_SINE) ? S_SINE_IDX : S_BLEP_CMP;
        end
      end
      S_SINE_IDX: begin
        idx_nxt   = sine_prod[PW+AW-1:PW];
        state_nxt = S_SINE_RD;
      end
      S_SINE_RD: begin
        state_nxt = S_SINE_DAT;
      end
      S_SINE_DAT: begin
        acc_nxt   = work_t'(rom_q_r);
        state_nxt = S_OUT;
      end
      // Near the start of the period, or near its end
      S_BLEP_CMP: begin
        lo_nxt    = q_cur < inc_r;
        num_nxt   = {1'b1, {PW{1'b0}}} - {1'b0, q_cur};
        state_nxt = S_BLEP_SEL;
      end
      S_BLEP_SEL: begin
        if (lo_r || hi) begin
          div_start = 1'b1;
          state_nxt = S_BLEP_DIV;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = route;
        end
      end
      S_BLEP_DIV: begin
        if (div_done) begin
          state_nxt = S_BLEP_MUL;
        end
      end
      S_BLEP_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_BLEP_ACC;
      end
      // First pass removes the edge at the phase, second adds the mid edge
      S_BLEP_ACC: begin
        acc_nxt   = pass_r ? (acc_r + blep) : (acc_r - blep);
        pass_nxt  = 1'b1;
        state_nxt = route;
      end
      S_TRI_MUL: begin
        prod_nxt  = mul_p;
        neg_nxt   = acc_r[WORK_W-1];
        state_nxt = S_TRI_ADD;
      end
      S_TRI_ADD: begin
        integ_nxt = INTEG_W'(tri_cl);
        acc_nxt   = tri_cl;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Clamp, round half up and rescale to the sample format
  always_comb begin
    out_cl     = clamp2(acc_r);
    out_scaled = ((out_cl <<< OUT_SHL) + RND) >>> OUT_SHR;
    res_sample = out_scaled[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      integ_r <= INTEG_ONE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      integ_r <= integ_nxt;
    end
    p_r    <= p_nxt;
    inc_r  <= inc_nxt;
    wf_r   <= wf_nxt;
    pass_r <= pass_nxt;
    lo_r   <= lo_nxt;
    num_r  <= num_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
  end

  // Sine table read port
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_TBL[idx_r];
  end

  assign idle = (state_r == S_IDLE);

endmodule

[rtl/polyblep_waveform_oscillator_top.sv]
// PolyBLEP waveform oscillator: top level with configuration registers and output register.
// Depends on pbo_pkg and pbo_ctrl (which uses pbo_div).
//
// Usage:
//   Input channel (in_valid/in_ready/in_sync): one transaction per output sample;
//   in_sync=1 clears the phase and sets the triangle integrator to 1.0 first.
//   Output channel (out_valid/out_ready/out_sample): one signed Q2.(W-3) sample
//   per input transaction, in order.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 selects the
//   waveform (0 sine, 1 saw, 2 square, 3 triangle), index 1 the Q0.32 phase
//   increment. Always ready; write only while no sample is in flight.
// Timing: one sample at a time. Sine runs through its index, table read and data states;
//   saw, square and triangle run a polyBLEP compare and select for each edge (saw one
//   edge, the others two), and each edge in reach adds a 28-step divider pass with its
//   set-up and multiply; triangle then adds a multiply and an add. in_ready rises with
//   out_valid, as the result is loaded into the output register.
// Reset: synchronous, active low; phase 0, integrator 1.0, saw, increment 42950.
// Stall: the finished sample sits in the output register; a new transaction
//   is accepted meanwhile, and its result waits until that register frees.
`timescale 1ns / 1ps

module polyblep_waveform_oscillator_top #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int PHASE_WIDTH      = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_sync,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbo_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pbo_pkg::*;

  pbo_cfg_t                       cfg_r, cfg_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;

  logic                           ctrl_idle;
  logic                           res_valid;
  logic signed [SAMPLE_WIDTH-1:0] res_sample;
  logic                           res_take;

  pbo_ctrl #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_WIDTH     (PHASE_WIDTH),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_pbo_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && ctrl_idle),
    .sync      (in_sync),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_sample(res_sample),
    .res_take  (res_take)
  );

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAVEFORM:  cfg_nxt.waveform        = cfg_data[1:0];
        CFG_PHASE_INC: cfg_nxt.phase_increment = cfg_data;
        default:       cfg_nxt                 = cfg_r;
      endcase
    end
  end

  // Output register: load when empty or being drained
  always_comb begin
    res_take       = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (res_valid && res_take) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res_sample;
    end else if (out_ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform        <= WAVEFORM_RST;
      cfg_r.phase_increment <= PHASE_INC_RST;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r                 <= cfg_nxt;
      out_valid_r           <= out_valid_nxt;
    end
    out_sample_r <= out_sample_nxt;
  end

  assign in_ready   = ctrl_idle;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

[rtl/pbo_checker.sv]
// Port-level checks for the polyBLEP oscillator top, attached by bind.
// Depends on polyblep_waveform_oscillator_top only through its ports.
`timescale 1ns / 1ps

module pbo_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_sync,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  // Full scale after saturation to +-2.0
  localparam logic signed [SAMPLE_WIDTH-1:0] PEAK = SAMPLE_WIDTH'(1) <<< (SAMPLE_WIDTH - 2);

  // Stalled input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_sync)))
    else $error("input transaction dropped or changed while stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("result changed or vanished while stalled");

  // One sample at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while a sample is in progress");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Samples stay within the saturated range
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_sample <= PEAK) && (out_sample >= -PEAK)))
    else $error("sample beyond +-2.0");

endmodule

bind polyblep_waveform_oscillator_top pbo_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_pbo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_sync   (in_sync),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_sample(out_sample)
);

[verif/tb.sv]
// Self-checking testbench for polyblep_waveform_oscillator_top: all four waveforms, sync,
// every increment class and random handshake pressure on the input and output channels.
// Depends on pbo_pkg and the oscillator RTL only.
`timescale 1ns / 1ps

module tb;
  import pbo_pkg::*;

  localparam int SW          = 24;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_SHIFT  = 32 - $clog2(SINE_DEPTH);
  localparam int FB          = FRAC_BITS;
  localparam int RND_SHIFT   = 31 - SW;
  localparam int SETTLE      = 80;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int RAND_ITEMS  = 1950;

  localparam longint          UNITY      = 64'sd1 <<< FB;
  localparam longint unsigned PH_FULL    = 64'd1 << 32;
  localparam longint unsigned PH_HALF    = 64'd1 << 31;
  localparam longint unsigned PH_MASK    = PH_FULL - 64'd1;
  localparam longint unsigned PI_OVER_2  = 64'd1686629713;
  localparam longint          OUT_MAX    = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam longint          OUT_MIN    = -(64'sd1 <<< (SW - 1));

  // DUT ports
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_sync   = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SW-1:0]  out_sample;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Stimulus and scoreboard
  logic                  pending_syncs[$];
  logic signed [SW-1:0]  expected_samples[$];
  logic signed [SW-1:0]  exp_s;
  int                    err_cnt    = 0;
  int unsigned           cycle_cnt  = 0;
  int                    tx_mode    = 0;
  int                    rx_mode    = 0;
  int                    burst_left = 0;
  int                    gap_left   = 0;
  int                    stall_left = 0;

  // Predictor state and configuration copy
  logic [1:0]            cur_wave;
  logic [31:0]           cur_inc;
  longint unsigned       osc_phase;
  longint                tri_acc;
  longint                sine_lut [SINE_DEPTH];

  polyblep_waveform_oscillator_top #(
    .SAMPLE_WIDTH    (SW),
    .PHASE_WIDTH     (32),
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sync   (in_sync),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Restoring division, num < den: num/den in Q0.28, truncated
  function automatic longint blep_ratio(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = num;
    quo = 0;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return $signed(quo);
  endfunction

  // polyBLEP residual: leading edge takes precedence over the wrap edge
  function automatic longint blep_term(longint unsigned ph, longint unsigned inc);
    longint t;
    if (ph < inc) begin
      t = blep_ratio(ph, inc);
      return (((2 * UNITY - t) * t) >>> FB) - UNITY;
    end
    if (PH_FULL - ph < inc) begin
      t = blep_ratio(PH_FULL - ph, inc);
      return UNITY - (((2 * UNITY - t) * t) >>> FB);
    end
    return 0;
  endfunction

  function automatic longint sat2(longint v);
    if (v > 2 * UNITY) return 2 * UNITY;
    if (v < -2 * UNITY) return -2 * UNITY;
    return v;
  endfunction

  // Table entry: quarter-wave Taylor series in Q30, reduced to Q28
  function automatic longint sine_value(int unsigned k);
    longint unsigned f;
    longint unsigned r;
    longint unsigned x;
    longint unsigned term;
    longint unsigned quad;
    longint          acc;
    f    = (64'(k) << 32) / SINE_DEPTH;
    quad = (f >> 30) & 64'd3;
    r    = f & ((64'd1 << 30) - 64'd1);
    if (quad[0]) r = (64'd1 << 30) - r;
    x    = (r * PI_OVER_2) >> 30;
    acc  = $signed(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 2) >>> 2;
    return (quad >= 2) ? -acc : acc;
  endfunction

  initial begin
    for (int k = 0; k < SINE_DEPTH; k++) sine_lut[k] = sine_value(k);
  end

  // One sample of the oscillator; advances phase and integrator
  function automatic logic signed [SW-1:0] predict_sample(logic sync);
    longint unsigned p;
    longint unsigned inc;
    longint unsigned rnd;
    longint          v;
    longint          sq;
    longint          mag;
    if (sync) begin
      osc_phase = 0;
      tri_acc   = UNITY;
    end
    p   = osc_phase;
    inc = 64'(cur_inc);
    case (cur_wave)
      WF_SINE: v = sine_lut[p >> SINE_SHIFT];
      WF_SAW:  v = 2 * $signed(p >> (32 - FB)) - UNITY - blep_term(p, inc);
      default: begin
        sq = (p < PH_HALF ? -UNITY : UNITY) - blep_term(p, inc)
             + blep_term((p + PH_HALF) & PH_MASK, inc);
        if (cur_wave == WF_SQUARE) begin
          v = sq;
        end else begin
          mag     = (sq < 0) ? -sq : sq;
          mag     = $signed((inc * $unsigned(mag)) >> 30);
          tri_acc = sat2(tri_acc + ((sq < 0) ? -mag : mag));
          v       = tri_acc;
        end
      end
    endcase
    osc_phase = (p + inc) & PH_MASK;
    // Q.28 to output format, round half up, then saturate
    v   = sat2(v);
    rnd = ($unsigned(v + (64'sd1 <<< 31)) + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    v   = $signed(rnd) - (64'sd1 <<< (31 - RND_SHIFT));
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[SW-1:0];
  endfunction

  // Track configuration writes and accepted input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_wave  = WAVEFORM_RST;
      cur_inc   = PHASE_INC_RST;
      osc_phase = 0;
      tri_acc   = UNITY;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WAVEFORM:  cur_wave = cfg_data[1:0];
          CFG_PHASE_INC: cur_inc  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_samples.push_back(predict_sample(in_sync));
    end
  end

  // Input driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sync  <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_syncs.size() != 0) begin
        in_valid <= 1'b1;
        in_sync  <= pending_syncs.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          case (tx_mode)
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(0, 4);
            default: gap_left = $urandom_range(0, 140);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: ready by default, stalls of mode-dependent length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_mode != 0 && $urandom_range(0, 11) == 0)
        stall_left = (rx_mode == 1) ? $urandom_range(1, 6) : $urandom_range(1, 150);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("sample %0d arrived with none expected", out_sample);
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_sample !== exp_s) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("sample mismatch: expected %0d, got %0d", exp_s, out_sample);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // All transactions sent and answered, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_syncs.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_directed(logic [1:0] wave, logic [31:0] inc, int n, logic [3:0] syncs);
    write_reg(CFG_WAVEFORM, 32'(wave));
    write_reg(CFG_PHASE_INC, inc);
    for (int i = 0; i < n; i++) pending_syncs.push_back(syncs[i]);
    wait_idle();
  endtask

  initial begin
    int          n;
    int          rand_items;
    logic [31:0] inc;
    rand_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration, first sample from reset state, then a sync
    pending_syncs.push_back(1'b0);
    pending_syncs.push_back(1'b1);
    pending_syncs.push_back(1'b0);
    wait_idle();

    // Directed corners
    run_directed(WF_SINE,     32'h4000_0000, 4, 4'b0000);  // one step per quadrant
    run_directed(WF_SAW,      32'h8000_0000, 2, 4'b0000);  // largest legal increment
    run_directed(WF_SQUARE,   32'hFFFF_FFFF, 3, 4'b0000);  // increment above one half
    run_directed(WF_TRIANGLE, 32'h8000_0000, 4, 4'b1000);  // integrator saturation, resync
    run_directed(WF_SAW,      32'h0000_0000, 2, 4'b0000);  // zero increment: no blep
    run_directed(WF_TRIANGLE, 32'h0000_0001, 2, 4'b0001);  // slowest slope
    run_directed(WF_SQUARE,   32'h7FFF_FFFF, 3, 4'b0000);  // both edges in reach

    // Random phases: new settings, new idling pattern, a batch of ticks
    while (rand_items < RAND_ITEMS) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      write_reg(CFG_WAVEFORM, 32'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0:       inc = $urandom_range(1, 255);
        1, 2:    inc = $urandom_range(1, 1 << 20);
        3, 4, 5: inc = $urandom_range(1 << 20, 32'h1000_0000);
        6, 7:    inc = $urandom_range(32'h1000_0000, 32'h8000_0000);
        8:       inc = 32'h8000_0000 - $urandom_range(0, 3);
        default: inc = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PHASE_INC, inc);
      n = $urandom_range(10, 90);
      for (int i = 0; i < n; i++) pending_syncs.push_back($urandom_range(0, 15) == 0);
      rand_items += n;
      wait_idle();
    end

    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
